// ===== sv/sfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcc_pkg
// Shared types, constants and the CRC-8 byte update for the sensor frame
// CRC checker.
// ----------------------------------------------------------------------------
package sfcc_pkg;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   localparam logic [2:0] POS_T_HI  = 3'd0;
   localparam logic [2:0] POS_T_LO  = 3'd1;
   localparam logic [2:0] POS_T_CRC = 3'd2;
   localparam logic [2:0] POS_H_HI  = 3'd3;
   localparam logic [2:0] POS_H_LO  = 3'd4;
   localparam logic [2:0] POS_H_CRC = 3'd5;

   typedef struct packed {
      logic [15:0] temperature_hundredths;
      logic [15:0] humidity_hundredths;
      logic        frame_ok;
   } result_type;

   // MSB-first CRC-8 over one byte, no final XOR
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/sfcc_req_if.sv =====
// ----------------------------------------------------------------------------
// sfcc_req_if
// Byte channel into the sensor frame CRC checker.
// ----------------------------------------------------------------------------
interface sfcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== sv/sfcc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sfcc_rsp_if
// Result channel out of the sensor frame CRC checker.
// ----------------------------------------------------------------------------
interface sfcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] temperature_hundredths;
   logic [15:0] humidity_hundredths;
   logic        frame_ok;

   modport source (output valid, output temperature_hundredths,
                   output humidity_hundredths, output frame_ok, input ready);
   modport sink   (input valid, input temperature_hundredths,
                   input humidity_hundredths, input frame_ok, output ready);
endinterface

// ===== sv/sfcc_frame_check.sv =====
// ----------------------------------------------------------------------------
// sfcc_frame_check
// Frame position tracking, running CRC and word capture; flags the sixth
// byte of a frame and presents the finished result.
// ----------------------------------------------------------------------------
module sfcc_frame_check (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 frame_start,
   output logic                 result_due,
   output logic                 result_fire,
   output sfcc_pkg::result_type result
);
   import sfcc_pkg::*;

   logic [2:0]  pos_ff, pos_in, pos_eff;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] temp_ff, temp_in;
   logic [7:0]  hum_hi_ff, hum_hi_in;
   logic [7:0]  hum_lo_ff, hum_lo_in;
   logic        first_good_ff, first_good_in;

   always_comb begin
      pos_eff = (frame_start || (pos_ff > POS_H_CRC)) ? POS_T_HI : pos_ff;
      result_due    = (pos_eff == POS_H_CRC);
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      temp_in       = temp_ff;
      hum_hi_in     = hum_hi_ff;
      hum_lo_in     = hum_lo_ff;
      first_good_in = first_good_ff;
      result_fire   = 1'b0;
      if (step) begin
         pos_in = (pos_eff >= POS_H_CRC) ? POS_T_HI : pos_eff + 3'd1;
         unique case (pos_eff)
            POS_T_LO: begin
               crc_in  = crc8_update(crc_ff, data_byte);
               temp_in = {temp_ff[15:8], data_byte};
            end
            POS_T_CRC: begin
               first_good_in = (crc_ff == data_byte);
               crc_in        = CRC_INIT;
            end
            POS_H_HI: begin
               crc_in    = crc8_update(CRC_INIT, data_byte);
               hum_hi_in = data_byte;
            end
            POS_H_LO: begin
               crc_in    = crc8_update(crc_ff, data_byte);
               hum_lo_in = data_byte;
            end
            POS_H_CRC: begin
               result_fire = 1'b1;
               crc_in      = CRC_INIT;
            end
            default: begin
               crc_in  = crc8_update(CRC_INIT, data_byte);
               temp_in = {data_byte, 8'h00};
            end
         endcase
      end
   end

   assign result.temperature_hundredths = temp_ff;
   assign result.humidity_hundredths    = {hum_hi_ff, hum_lo_ff};
   assign result.frame_ok               = first_good_ff && (crc_ff == data_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_T_HI;
         crc_ff        <= CRC_INIT;
         temp_ff       <= 16'h0000;
         hum_hi_ff     <= 8'h00;
         hum_lo_ff     <= 8'h00;
         first_good_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         temp_ff       <= temp_in;
         hum_hi_ff     <= hum_hi_in;
         hum_lo_ff     <= hum_lo_in;
         first_good_ff <= first_good_in;
      end
   end

endmodule

// ===== sv/sensor_frame_crc_checker_top.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_crc_checker_top
// Checks six-byte sensor responses: temperature word + CRC, humidity word +
// CRC, CRC-8 poly 0x31 init 0xFF, and emits both words with a pass flag.
//
// Usage:
//   req carries one response byte per item with frame_start marking byte 0;
//   without frame_start the byte count wraps after the sixth byte, and a
//   frame_start in mid-frame drops the partial frame.
//   rsp carries one item per completed frame: both raw words (hundredths)
//   and frame_ok, set only when both word CRCs match.
//   Throughput: one byte per cycle while no sixth byte waits on rsp, set by
//   the combinational byte-wide CRC update ahead of the running CRC register.
//   Path: an accepted byte is processed from the input register; the result
//   of a sixth byte is loaded into the result register and shown on rsp.
//   Reset (synchronous): both stages empty, byte count at zero, CRC at 0xFF.
//   Stall: a waiting result holds; bytes that produce no result keep
//   flowing, and a sixth byte waits in the input register until the result
//   register frees up, which then holds off req.
// ----------------------------------------------------------------------------
module sensor_frame_crc_checker_top (
   input logic          clock,
   input logic          reset,
   sfcc_req_if.sink     req,
   sfcc_rsp_if.source   rsp
);
   import sfcc_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_start_ff;
   logic       s1_advance;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       out_free;
   logic       result_due;
   logic       result_fire;
   logic       result_load;
   result_type result;

   sfcc_frame_check u_frame_check (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_advance),
      .data_byte   (s1_byte_ff),
      .frame_start (s1_start_ff),
      .result_due  (result_due),
      .result_fire (result_fire),
      .result      (result)
   );

   assign out_free    = !out_valid_ff || rsp.ready;
   assign s1_advance  = s1_valid_ff && (out_free || !result_due);
   assign result_load = result_fire;
   assign req.ready   = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req.valid && req.ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (result_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_byte_ff  <= req.data_byte;
         s1_start_ff <= req.frame_start;
      end
      if (result_load) begin
         out_ff <= result;
      end
   end

   assign rsp.valid                  = out_valid_ff;
   assign rsp.temperature_hundredths = out_ff.temperature_hundredths;
   assign rsp.humidity_hundredths    = out_ff.humidity_hundredths;
   assign rsp.frame_ok               = out_ff.frame_ok;

`ifndef SYNTHESIS
   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      result_load |-> out_free)
      else $error("result loaded over an unaccepted result");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_byte_ff)))
      else $error("stalled input byte lost");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req.ready)
      else $error("empty input stage not ready");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !out_valid_ff))
      else $error("stages not empty after reset");
`endif

endmodule
